FILE: design/mmf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the matrix multiply engine with flush.
// No dependencies; used by the top level and its checker.
package mmf_pkg;

  // Default largest matrix dimension held in the element stores.
  localparam int DEFAULT_MAX_DIM = 16;

  // Field widths fixed by the interface.
  localparam int REQ_W    = 2;
  localparam int IDX_W    = 4;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int DIM_W    = 5;
  localparam int THR_W    = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_THR = 3'd4;

  // Saturation limits in Q16.16.
  localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

FILE: design/matrix_multiply_with_flush_top.sv
`timescale 1ns / 1ps
// Matrix product engine: element stores for A and B, one shared multiply-accumulate
// unit under a small sequencer, saturation and small-value flush. Depends on mmf_pkg.
//
//  Channel  Direction  Handshake                Payload
//  in_      input      in_valid / in_stall      req_type, row_index, col_index, elem_value
//  out_     output     out_valid / out_stall    prod_row, prod_col, prod_value, status
//  cfg_     input      cfg_we                   cfg_index, cfg_data
//
// A load item is accepted whenever the block is idle. A compute item is accepted, then
// makes one store read and one multiply-accumulate per cycle through the single multiplier
// for n = min(inner_dim, MAX_DIM) inner steps, drains the pipeline and finishes. An
// out-of-range compute item goes straight to its finish step. Reset is synchronous and clears
// control state only; the stores are not cleared. A result waiting under out_stall
// lets loads continue, and a compute item holds in its finish step until it clears.
module matrix_multiply_with_flush_top #(
  parameter int MAX_DIM = mmf_pkg::DEFAULT_MAX_DIM
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mmf_pkg::REQ_W-1:0]        in_req_type,
  input  logic [mmf_pkg::IDX_W-1:0]        in_row_index,
  input  logic [mmf_pkg::IDX_W-1:0]        in_col_index,
  input  logic signed [mmf_pkg::VAL_W-1:0] in_elem_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mmf_pkg::IDX_W-1:0]        out_prod_row,
  output logic [mmf_pkg::IDX_W-1:0]        out_prod_col,
  output logic signed [mmf_pkg::VAL_W-1:0] out_prod_value,
  output logic [mmf_pkg::STATUS_W-1:0]     out_status,
  input  logic                             cfg_we,
  input  logic [mmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_DIM + 1);
  localparam int PW    = 2 * mmf_pkg::VAL_W;
  localparam int ACC_W = PW + $clog2(MAX_DIM);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // True when an index lies below both a register limit and the store size.
  function automatic logic in_dim(input logic [mmf_pkg::IDX_W-1:0] idx,
                                  input logic [mmf_pkg::DIM_W-1:0] lim);
    return ({1'b0, idx} < lim) && (32'(idx) < MAX_DIM);
  endfunction

  // Configuration registers.
  logic [mmf_pkg::DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic                      flush_en_r;
  logic [mmf_pkg::THR_W-1:0] flush_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= 5'd16;
      inner_dim_r <= 5'd16;
      cols_b_r    <= 5'd16;
      flush_en_r  <= 1'b0;
      flush_thr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mmf_pkg::CFG_ROWS_A:    rows_a_r    <= cfg_data[mmf_pkg::DIM_W-1:0];
        mmf_pkg::CFG_INNER_DIM: inner_dim_r <= cfg_data[mmf_pkg::DIM_W-1:0];
        mmf_pkg::CFG_COLS_B:    cols_b_r    <= cfg_data[mmf_pkg::DIM_W-1:0];
        mmf_pkg::CFG_FLUSH_EN:  flush_en_r  <= cfg_data[0];
        mmf_pkg::CFG_FLUSH_THR: flush_thr_r <= cfg_data[mmf_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and working registers.
  logic [1:0]                state_r, state_nxt;
  logic [mmf_pkg::IDX_W-1:0] row_r, col_r;
  logic [KW-1:0]             k_r, n_r;
  logic                      err_r;
  logic                      rd_vld_r, mul_vld_r;
  logic signed [mmf_pkg::VAL_W-1:0] a_q_r, b_q_r;
  logic signed [PW-1:0]      prod_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic in_acc, is_load_a, is_load_b, is_comp, comp_ok, issue, out_free;
  logic [KW-1:0] n_eff;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_load_a = in_acc && (in_req_type == mmf_pkg::REQ_LOAD_A)
                     && in_dim(in_row_index, rows_a_r) && in_dim(in_col_index, inner_dim_r);
  assign is_load_b = in_acc && (in_req_type == mmf_pkg::REQ_LOAD_B)
                     && in_dim(in_row_index, inner_dim_r) && in_dim(in_col_index, cols_b_r);
  assign is_comp   = in_acc && (in_req_type == mmf_pkg::REQ_COMPUTE);
  assign comp_ok   = in_dim(in_row_index, rows_a_r) && in_dim(in_col_index, cols_b_r);
  assign n_eff     = (32'(inner_dim_r) < MAX_DIM) ? KW'(inner_dim_r) : KW'(MAX_DIM);
  assign issue     = (state_r == ST_RUN) && (k_r < n_r);
  assign out_free  = !out_valid || !out_stall;

  // Store addresses: loads from the input, reads from the running inner index.
  logic [AW-1:0] wr_addr, a_rd_addr, b_rd_addr;
  assign wr_addr   = AW'(32'(in_row_index) * MAX_DIM + 32'(in_col_index));
  assign a_rd_addr = AW'(32'(row_r) * MAX_DIM + 32'(k_r));
  assign b_rd_addr = AW'(32'(k_r) * MAX_DIM + 32'(col_r));

  // Element stores with registered reads.
  logic [mmf_pkg::VAL_W-1:0] a_mem [DEPTH];
  logic [mmf_pkg::VAL_W-1:0] b_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (is_load_a) a_mem[wr_addr] <= in_elem_value;
    if (issue)     a_q_r <= a_mem[a_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (is_load_b) b_mem[wr_addr] <= in_elem_value;
    if (issue)     b_q_r <= b_mem[b_rd_addr];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (is_comp) state_nxt = comp_ok ? ST_RUN : ST_FIN;
      ST_RUN:  if (!issue && !rd_vld_r && !mul_vld_r) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers of the sequencer and the multiply pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_vld_r  <= 1'b0;
      mul_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= issue;
      mul_vld_r <= rd_vld_r;
    end
  end

  // Item capture, inner index and the shared multiply-accumulate unit.
  always_ff @(posedge clk) begin
    if (is_comp) begin
      row_r <= in_row_index;
      col_r <= in_col_index;
      err_r <= !comp_ok;
      n_r   <= n_eff;
      k_r   <= '0;
      acc_r <= '0;
    end else begin
      if (issue)     k_r <= k_r + 1'b1;
      if (mul_vld_r) acc_r <= acc_r + {{(ACC_W-PW){prod_r[PW-1]}}, prod_r};
    end
    if (rd_vld_r) prod_r <= a_q_r * b_q_r;
  end

  // Truncate to Q16.16, saturate, then flush small magnitudes.
  logic [ACC_W-48:0]         hi_bits;
  logic                      fits;
  logic [mmf_pkg::VAL_W-1:0] trunc, mag, fin_value;
  logic [mmf_pkg::STATUS_W-1:0] fin_status;

  assign hi_bits = acc_r[ACC_W-1:47];
  assign fits    = (&hi_bits) || !(|hi_bits);
  assign trunc   = acc_r[47:16];
  assign mag     = trunc[31] ? (32'd0 - trunc) : trunc;

  always_comb begin
    fin_status = mmf_pkg::STATUS_OK;
    fin_value  = trunc;
    if (err_r) begin
      fin_status = mmf_pkg::STATUS_RANGE;
      fin_value  = '0;
    end else if (!fits) begin
      fin_status = mmf_pkg::STATUS_SAT;
      fin_value  = acc_r[ACC_W-1] ? mmf_pkg::SAT_NEG : mmf_pkg::SAT_POS;
    end else if (flush_en_r && (mag < {1'b0, flush_thr_r})) begin
      fin_value = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if ((state_r == ST_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      out_prod_row   <= row_r;
      out_prod_col   <= col_r;
      out_prod_value <= fin_value;
      out_status     <= fin_status;
    end
  end

endmodule

FILE: design/mmf_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the matrix multiply engine, with its bind statement.
// Depends on mmf_pkg and the top level matrix_multiply_with_flush_top.
module mmf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [mmf_pkg::REQ_W-1:0]        in_req_type,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [mmf_pkg::VAL_W-1:0] out_prod_value,
  input logic [mmf_pkg::STATUS_W-1:0]     out_status
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A compute item makes the block busy in the next cycle.
  a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == mmf_pkg::REQ_COMPUTE) |=> in_stall)
    else $error("compute item did not occupy the engine");

  // An index error always carries a zero value.
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == mmf_pkg::STATUS_RANGE) |-> (out_prod_value == 0))
    else $error("range error with nonzero value");

  // A saturated result sits at one of the two limits.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == mmf_pkg::STATUS_SAT) |->
      (out_prod_value == mmf_pkg::SAT_POS) || (out_prod_value == mmf_pkg::SAT_NEG))
    else $error("saturated result off the limits");

  // No result carries the unused status code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == mmf_pkg::STATUS_OK) || (out_status == mmf_pkg::STATUS_SAT)
      || (out_status == mmf_pkg::STATUS_RANGE))
    else $error("unknown result status");

endmodule

bind matrix_multiply_with_flush_top mmf_checker u_mmf_checker (.*);

FILE: tb/matrix_multiply_with_flush_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply_with_flush_top: shadow stores predict
// each product element, results are compared in order. Depends on mmf_pkg and the top.
module matrix_multiply_with_flush_top_tb;
  import mmf_pkg::*;

  localparam int MAX_DIM      = DEFAULT_MAX_DIM;
  localparam int DRAIN_CYCLES = MAX_DIM + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 500000;

  // Request code that the block ignores.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic [STATUS_W-1:0]     status;
  } product_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [REQ_W-1:0] in_req_type;
  logic [IDX_W-1:0] in_row_index;
  logic [IDX_W-1:0] in_col_index;
  logic signed [VAL_W-1:0] in_elem_value;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_prod_row;
  logic [IDX_W-1:0] out_prod_col;
  logic signed [VAL_W-1:0] out_prod_value;
  logic [STATUS_W-1:0] out_status;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the configuration and of both element stores.
  logic [DIM_W-1:0] cfg_rows = 5'd16;
  logic [DIM_W-1:0] cfg_inner = 5'd16;
  logic [DIM_W-1:0] cfg_cols = 5'd16;
  logic cfg_flush_en = 1'b0;
  logic [THR_W-1:0] cfg_flush_thr = '0;
  logic signed [VAL_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [VAL_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  bit a_written [MAX_DIM*MAX_DIM];
  bit b_written [MAX_DIM*MAX_DIM];

  product_t product_expect_q [$];
  int fail_count = 0;
  int applied_items = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  bit hold_request = 1'b0;
  bit holding = 1'b0;

  matrix_multiply_with_flush_top #(.MAX_DIM(MAX_DIM)) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_row_index  (in_row_index),
    .in_col_index  (in_col_index),
    .in_elem_value (in_elem_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_prod_row  (out_prod_row),
    .out_prod_col  (out_prod_col),
    .out_prod_value(out_prod_value),
    .out_status    (out_status),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Number of usable indexes for a size register.
  function automatic int dim_limit(logic [DIM_W-1:0] size);
    return (size < MAX_DIM) ? int'(size) : MAX_DIM;
  endfunction

  function automatic bit compute_in_range(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    return (row < dim_limit(cfg_rows)) && (col < dim_limit(cfg_cols));
  endfunction

  // Exact dot product, floor shift to Q16.16, saturation, then small-value flush.
  function automatic product_t predict_product(logic [IDX_W-1:0] row,
                                               logic [IDX_W-1:0] col);
    product_t res;
    logic signed [127:0] acc_sum;
    logic signed [127:0] shifted;
    logic signed [63:0] term;
    logic [VAL_W-1:0] mag;
    res.row = row;
    res.col = col;
    res.value = '0;
    res.status = STATUS_RANGE;
    if (!compute_in_range(row, col)) return res;
    acc_sum = '0;
    for (int k = 0; k < dim_limit(cfg_inner); k++) begin
      term = a_mem[row * MAX_DIM + k] * b_mem[k * MAX_DIM + col];
      acc_sum = acc_sum + term;
    end
    shifted = acc_sum >>> 16;
    res.status = STATUS_OK;
    if (shifted[127:31] == '0 || shifted[127:31] == '1) begin
      res.value = shifted[VAL_W-1:0];
    end else begin
      res.value = shifted[127] ? SAT_NEG : SAT_POS;
      res.status = STATUS_SAT;
    end
    if (cfg_flush_en && res.status == STATUS_OK) begin
      mag = res.value;
      if (mag[VAL_W-1]) mag = -mag;
      if (mag < {1'b0, cfg_flush_thr}) res.value = '0;
    end
    return res;
  endfunction

  // Apply one accepted item to the shadow stores and queue its product, if any.
  function automatic void absorb_item(logic [REQ_W-1:0] req, logic [IDX_W-1:0] row,
                                      logic [IDX_W-1:0] col, logic [VAL_W-1:0] val);
    case (req)
      REQ_LOAD_A: begin
        if (row < dim_limit(cfg_rows) && col < dim_limit(cfg_inner)) begin
          a_mem[row * MAX_DIM + col] = val;
          a_written[row * MAX_DIM + col] = 1'b1;
          applied_items++;
        end
      end
      REQ_LOAD_B: begin
        if (row < dim_limit(cfg_inner) && col < dim_limit(cfg_cols)) begin
          b_mem[row * MAX_DIM + col] = val;
          b_written[row * MAX_DIM + col] = 1'b1;
          applied_items++;
        end
      end
      REQ_COMPUTE: begin
        product_expect_q.insert(product_expect_q.size(), predict_product(row, col));
        applied_items++;
      end
      default: ;
    endcase
  endfunction

  // Element values: mostly near unity so sums stay in range, some full width.
  function automatic logic [VAL_W-1:0] rand_elem();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return int'($urandom_range(262143)) - 131072;
    if (pick < 65) return int'($urandom_range(2097151)) - 1048576;
    if (pick < 85) return $urandom();
    case ($urandom_range(6))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return 32'hFFFF_0000;
      4: return 32'h0000_0001;
      5: return 32'hFFFF_FFFF;
      default: return 32'h0000_0000;
    endcase
  endfunction

  // Mostly an index below the limit, now and then any index.
  function automatic logic [IDX_W-1:0] pick_index(int lim);
    logic [IDX_W-1:0] idx;
    if (lim > 0 && $urandom_range(9) != 0) idx = IDX_W'($urandom_range(lim - 1));
    else idx = IDX_W'($urandom_range(15));
    return idx;
  endfunction

  // Offer one item, with a random gap before it, and wait until it is taken.
  task automatic send_item(logic [REQ_W-1:0] req, logic [IDX_W-1:0] row,
                           logic [IDX_W-1:0] col, logic [VAL_W-1:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_row_index <= row;
    in_col_index <= col;
    in_elem_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_item(req, row, col, val);
  endtask

  // Stop offering, wait for every product, then let loads settle.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (product_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_ROWS_A:    cfg_rows = data[DIM_W-1:0];
      CFG_INNER_DIM: cfg_inner = data[DIM_W-1:0];
      CFG_COLS_B:    cfg_cols = data[DIM_W-1:0];
      CFG_FLUSH_EN:  cfg_flush_en = data[0];
      CFG_FLUSH_THR: cfg_flush_thr = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Rewrite every register once the block is idle.
  task automatic apply_settings(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] inner,
                                logic [DIM_W-1:0] cols, logic fen, logic [THR_W-1:0] thr);
    wait_for_quiet();
    write_reg(CFG_ROWS_A, CFG_DATA_W'(rows));
    write_reg(CFG_INNER_DIM, CFG_DATA_W'(inner));
    write_reg(CFG_COLS_B, CFG_DATA_W'(cols));
    write_reg(CFG_FLUSH_EN, CFG_DATA_W'(fen));
    write_reg(CFG_FLUSH_THR, CFG_DATA_W'(thr));
    cfg_we <= 1'b0;
  endtask

  // Load whichever operands of product (row, col) have never been written.
  task automatic fill_operands(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    logic [IDX_W-1:0] k_idx;
    for (int k = 0; k < dim_limit(cfg_inner); k++) begin
      k_idx = IDX_W'(k);
      if (!a_written[row * MAX_DIM + k]) send_item(REQ_LOAD_A, row, k_idx, rand_elem());
      if (!b_written[k * MAX_DIM + col]) send_item(REQ_LOAD_B, k_idx, col, rand_elem());
    end
  endtask

  // Random traffic: product requests with their operands loaded first,
  // overwrites, loads that miss the range and requests of the unused type.
  task automatic random_traffic(int target);
    int start;
    int pick;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    start = applied_items;
    while (applied_items - start < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        row = pick_index(dim_limit(cfg_rows));
        col = pick_index(dim_limit(cfg_cols));
        if (compute_in_range(row, col)) fill_operands(row, col);
        send_item(REQ_COMPUTE, row, col, $urandom());
      end else if (pick < 85) begin
        if ($urandom_range(1) != 0) begin
          row = pick_index(dim_limit(cfg_rows));
          col = pick_index(dim_limit(cfg_inner));
          send_item(REQ_LOAD_A, row, col, rand_elem());
        end else begin
          row = pick_index(dim_limit(cfg_inner));
          col = pick_index(dim_limit(cfg_cols));
          send_item(REQ_LOAD_B, row, col, rand_elem());
        end
      end else if (pick < 95) begin
        row = IDX_W'($urandom_range(15));
        col = IDX_W'($urandom_range(15));
        if ($urandom_range(1) != 0) send_item(REQ_LOAD_A, row, col, rand_elem());
        else send_item(REQ_LOAD_B, row, col, rand_elem());
      end else begin
        send_item(REQ_UNUSED, 4'($urandom_range(15)), 4'($urandom_range(15)), $urandom());
      end
    end
  endtask

  // Saturation both ways, exact limits, floor rounding, range errors and flushing.
  task automatic test_directed_extremes();
    apply_settings(5'd16, 5'd1, 5'd16, 1'b0, '0);
    send_item(REQ_LOAD_A, 4'd15, 4'd0, 32'h7FFF_FFFF);
    send_item(REQ_LOAD_B, 4'd0, 4'd15, 32'h7FFF_FFFF);
    send_item(REQ_COMPUTE, 4'd15, 4'd15, 32'h0);
    send_item(REQ_LOAD_A, 4'd0, 4'd0, 32'h8000_0000);
    send_item(REQ_LOAD_B, 4'd0, 4'd0, 32'h8000_0000);
    send_item(REQ_COMPUTE, 4'd0, 4'd0, 32'h0);
    send_item(REQ_LOAD_B, 4'd0, 4'd1, 32'h7FFF_FFFF);
    send_item(REQ_COMPUTE, 4'd0, 4'd1, 32'h0);
    send_item(REQ_LOAD_A, 4'd1, 4'd0, 32'h0001_0000);
    send_item(REQ_LOAD_B, 4'd0, 4'd2, 32'hFFFF_0000);
    send_item(REQ_COMPUTE, 4'd1, 4'd2, 32'h0);
    send_item(REQ_COMPUTE, 4'd1, 4'd0, 32'h0);
    send_item(REQ_COMPUTE, 4'd1, 4'd15, 32'h0);
    send_item(REQ_LOAD_A, 4'd2, 4'd0, 32'h0000_0001);
    send_item(REQ_LOAD_B, 4'd0, 4'd3, 32'hFFFF_FFFF);
    send_item(REQ_COMPUTE, 4'd2, 4'd3, 32'h0);
    send_item(REQ_COMPUTE, 4'd2, 4'd1, 32'h0);
    send_item(REQ_UNUSED, 4'd15, 4'd15, 32'hFFFF_FFFF);
    // Loads outside the configured shape must leave the stores alone.
    send_item(REQ_LOAD_A, 4'd0, 4'd1, 32'h1234_5678);
    send_item(REQ_LOAD_B, 4'd1, 4'd0, 32'h1234_5678);
    apply_settings(5'd4, 5'd1, 5'd4, 1'b1, 31'h0001_0000);
    send_item(REQ_COMPUTE, 4'd4, 4'd0, 32'h0);
    send_item(REQ_COMPUTE, 4'd0, 4'd15, 32'h0);
    send_item(REQ_COMPUTE, 4'd1, 4'd2, 32'h0);
    send_item(REQ_COMPUTE, 4'd2, 4'd3, 32'h0);
    send_item(REQ_COMPUTE, 4'd0, 4'd0, 32'h0);
    send_item(REQ_LOAD_A, 4'd5, 4'd0, 32'hDEAD_BEEF);
    apply_settings(5'd4, 5'd1, 5'd4, 1'b1, 31'h7FFF_FFFF);
    send_item(REQ_COMPUTE, 4'd1, 4'd0, 32'h0);
    send_item(REQ_COMPUTE, 4'd1, 4'd2, 32'h0);
    send_item(REQ_COMPUTE, 4'd0, 4'd1, 32'h0);
  endtask

  task automatic test_random_full_size();
    apply_settings(5'd16, 5'd16, 5'd16, 1'b0, '0);
    random_traffic(180);
  endtask

  task automatic test_random_small_shapes();
    apply_settings(5'd3, 5'd5, 5'd2, 1'b1, 31'h0000_FFFF);
    random_traffic(200);
  endtask

  // Size registers above the store size are clamped to it.
  task automatic test_random_oversize_regs();
    apply_settings(5'd31, 5'd17, 5'd20, 1'b1, 31'h0040_0000);
    random_traffic(180);
  endtask

  // Empty inner sum, a single element, and no rows at all.
  task automatic test_random_degenerate();
    apply_settings(5'd1, 5'd0, 5'd1, 1'b1, 31'h0000_0001);
    random_traffic(30);
    apply_settings(5'd0, 5'd16, 5'd16, 1'b0, 31'h2A5A_5A5A);
    random_traffic(30);
  endtask

  // The receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_receiver_hold();
    apply_settings(5'd8, 5'd6, 5'd8, 1'b1, 31'h0000_8000);
    hold_request = 1'b1;
    random_traffic(60);
  endtask

  // The sender waits for every outstanding product between bursts.
  task automatic test_sender_pause();
    random_traffic(30);
    wait_for_quiet();
    random_traffic(30);
  endtask

  // Compare one accepted result with the oldest expected product.
  task automatic check_product();
    product_t exp_prod;
    if (product_expect_q.size() == 0) begin
      $error("result with no item waiting: row %0d col %0d value %0d status %0d",
             out_prod_row, out_prod_col, out_prod_value, out_status);
      fail_count++;
    end else begin
      exp_prod = product_expect_q.pop_front();
      if (out_prod_row !== exp_prod.row) begin
        $error("prod_row: expected %0d, actual %0d", exp_prod.row, out_prod_row);
        fail_count++;
      end
      if (out_prod_col !== exp_prod.col) begin
        $error("prod_col: expected %0d, actual %0d", exp_prod.col, out_prod_col);
        fail_count++;
      end
      if (out_prod_value !== exp_prod.value) begin
        $error("prod_value: expected %0d, actual %0d", exp_prod.value, out_prod_value);
        fail_count++;
      end
      if (out_status !== exp_prod.status) begin
        $error("status: expected %0d, actual %0d", exp_prod.status, out_status);
        fail_count++;
      end
    end
  endtask

  // Result side: check what is taken, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_product();
    out_stall <= holding || ($urandom_range(99) < recv_idle_pct);
  end

  // Long receiver hold-off, counted here once requested.
  initial begin
    wait (hold_request);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 1'b0;
  end

  // Run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_LOAD_A;
    in_row_index <= '0;
    in_col_index <= '0;
    in_elem_value <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ROWS_A;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 79;
    test_directed_extremes();
    test_random_full_size();

    send_idle_pct = 79;
    recv_idle_pct = 11;
    test_random_small_shapes();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_oversize_regs();
    test_random_degenerate();
    test_receiver_hold();
    test_sender_pause();

    wait_for_quiet();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/mmf_pkg.sv
design/matrix_multiply_with_flush_top.sv
design/mmf_checker.sv
tb/matrix_multiply_with_flush_top_tb.sv
